FILE: rtl/pdpl_pkg.sv
// ----------------------------------------------------------------------------
// PD position loop package
// Types, register codes and constants shared by the position loop modules.
// ----------------------------------------------------------------------------
package pdpl_pkg;

	// Configuration port geometry
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 20;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN   = 3'd0,
		REG_DAMP_GAIN   = 3'd1,
		REG_SPEED_LIMIT = 3'd2,
		REG_GEAR_FACTOR = 3'd3
	} reg_idx_t;

	// Register limits and reset values
	localparam logic [15:0] PROP_GAIN_MAX   = 16'd51200;
	localparam logic [13:0] DAMP_GAIN_MAX   = 14'd10240;
	localparam logic [19:0] SPEED_LIMIT_MAX = 20'd655360;
	localparam logic [15:0] PROP_GAIN_RST   = 16'd2048;
	localparam logic [13:0] DAMP_GAIN_RST   = 14'd307;
	localparam logic [19:0] SPEED_LIMIT_RST = 20'd65536;
	localparam logic [15:0] GEAR_FACTOR_RST = 16'd6400;

	// Gains, speed limit and gear factor of the loop
	typedef struct packed {
		logic [15:0] prop_gain;
		logic [13:0] damp_gain;
		logic [19:0] speed_limit;
		logic [15:0] gear_factor;
	} cfg_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_MUL_D,
		ST_MUL_G
	} ctrl_state_t;

	// Operand pair routed to the shared multiplier
	typedef enum logic [1:0] {
		MSEL_P,
		MSEL_D,
		MSEL_G
	} mul_sel_t;

	// Controller to datapath
	typedef struct packed {
		logic     take_sample;
		mul_sel_t mul_sel;
		logic     load_result;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic result_full;
		logic result_taken;
	} dp_stat_t;

endpackage

FILE: rtl/pdpl_if.sv
// ----------------------------------------------------------------------------
// PD position loop channels
// Valid/ready channels for the sample requests and the result requests.
// ----------------------------------------------------------------------------
interface pdpl_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] meas_position;
	logic signed [31:0] meas_velocity;
	logic               enable_level;
	logic signed [31:0] new_target;
	logic               target_load;

	modport source (output valid, meas_position, meas_velocity, enable_level,
		new_target, target_load, input ready);
	modport sink (input valid, meas_position, meas_velocity, enable_level,
		new_target, target_load, output ready);
	modport monitor (input valid, ready, meas_position, meas_velocity, enable_level,
		new_target, target_load);
endinterface

interface pdpl_out_if;
	logic               valid;
	logic               ready;
	logic signed [20:0] speed_command;
	logic signed [31:0] position_error;
	logic        [31:0] step_count;
	logic               loop_active;

	modport source (output valid, speed_command, position_error, step_count,
		loop_active, input ready);
	modport sink (input valid, speed_command, position_error, step_count,
		loop_active, output ready);
	modport monitor (input valid, ready, speed_command, position_error, step_count,
		loop_active);
endinterface

FILE: rtl/pdpl_cfg.sv
// ----------------------------------------------------------------------------
// PD position loop register bank
// Holds gains, limit and gear factor; gain and limit writes saturate to each range.
// ----------------------------------------------------------------------------
module pdpl_cfg import pdpl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Register writes, saturating for the gains and limit; unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain   <= PROP_GAIN_RST;
			cfg_q.damp_gain   <= DAMP_GAIN_RST;
			cfg_q.speed_limit <= SPEED_LIMIT_RST;
			cfg_q.gear_factor <= GEAR_FACTOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_PROP_GAIN: begin
					cfg_q.prop_gain <= (cfg_data[15:0] > PROP_GAIN_MAX) ?
						PROP_GAIN_MAX : cfg_data[15:0];
				end
				REG_DAMP_GAIN: begin
					cfg_q.damp_gain <= (cfg_data[13:0] > DAMP_GAIN_MAX) ?
						DAMP_GAIN_MAX : cfg_data[13:0];
				end
				REG_SPEED_LIMIT: begin
					cfg_q.speed_limit <= (cfg_data > SPEED_LIMIT_MAX) ?
						SPEED_LIMIT_MAX : cfg_data;
				end
				REG_GEAR_FACTOR: begin
					cfg_q.gear_factor <= cfg_data[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/pdpl_ctrl.sv
// ----------------------------------------------------------------------------
// PD position loop sequencer
// Steps one sample through the three products of the shared multiplier.
// ----------------------------------------------------------------------------
module pdpl_ctrl import pdpl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;
	logic        result_free;

	// Result register can take a new value when empty or drained this cycle
	assign result_free = !stat.result_full || stat.result_taken;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_nxt = ST_MUL_P;
			ST_MUL_P: state_nxt = ST_MUL_D;
			ST_MUL_D: state_nxt = ST_MUL_G;
			ST_MUL_G: if (result_free) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		in_ready        = 1'b0;
		cmd.take_sample = 1'b0;
		cmd.mul_sel     = MSEL_P;
		cmd.load_result = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready        = 1'b1;
				cmd.take_sample = in_valid;
			end
			ST_MUL_P: cmd.mul_sel = MSEL_P;
			ST_MUL_D: cmd.mul_sel = MSEL_D;
			ST_MUL_G: begin
				cmd.mul_sel     = MSEL_G;
				cmd.load_result = result_free;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: rtl/pdpl_dp.sv
// ----------------------------------------------------------------------------
// PD position loop datapath
// Loop state, error stage, shared multiplier and the result register.
// ----------------------------------------------------------------------------
module pdpl_dp import pdpl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	input  logic signed [31:0] meas_position,
	input  logic signed [31:0] meas_velocity,
	input  logic               enable_level,
	input  logic signed [31:0] new_target,
	input  logic               target_load,
	output logic               result_valid,
	input  logic               result_ready,
	output logic signed [20:0] speed_command,
	output logic signed [31:0] position_error,
	output logic        [31:0] step_count,
	output logic               loop_active
);

	// Loop state
	logic signed [31:0] target_q;
	logic signed [31:0] last_pos_q;
	logic               active_q;
	logic        [31:0] tick_q;

	// Per-sample stages
	logic signed [31:0] err_s1;
	logic signed [31:0] vel_s1;
	logic               en_s1;
	logic signed [37:0] p_s2;
	logic signed [29:0] diff_s3;

	// Result register
	logic               res_valid_q;
	logic signed [20:0] res_cmd_q;
	logic signed [31:0] res_err_q;
	logic        [31:0] res_tick_q;
	logic               res_active_q;

	logic               en_edge;
	logic signed [31:0] target_nxt;
	logic signed [32:0] err_wide;
	logic signed [31:0] err_sat;
	logic signed [31:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [48:0] prod;
	logic signed [38:0] diff_wide;
	logic signed [29:0] diff_sat;
	logic signed [37:0] cmd_wide;
	logic signed [37:0] lim_pos;
	logic signed [37:0] lim_neg;
	logic signed [20:0] cmd_clamp;

	localparam logic signed [38:0] DIFF_HI = 39'sd268435456;
	localparam logic signed [38:0] DIFF_LO = -39'sd268435456;

	// Setpoint update: load first, enable edge overrides
	assign en_edge = enable_level && !active_q;

	always_comb begin
		target_nxt = target_q;
		if (target_load) target_nxt = new_target;
		if (en_edge) target_nxt = last_pos_q;
	end

	// Saturated position error
	assign err_wide = 33'(target_nxt) - 33'(meas_position);

	always_comb begin
		if (err_wide[32] != err_wide[31]) begin
			err_sat = err_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			err_sat = err_wide[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= '0;
			last_pos_q <= '0;
			active_q   <= 1'b0;
			tick_q     <= '0;
		end else if (cmd.take_sample) begin
			target_q   <= target_nxt;
			last_pos_q <= meas_position;
			active_q   <= enable_level;
			if (en_edge) begin
				tick_q <= 32'd1;
			end else if (enable_level) begin
				tick_q <= tick_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_sample) begin
			err_s1 <= err_sat;
			vel_s1 <= meas_velocity;
			en_s1  <= enable_level;
		end
	end

	// Shared multiplier operand select
	always_comb begin
		case (cmd.mul_sel)
			MSEL_P: begin
				mul_a = err_s1;
				mul_b = $signed({1'b0, cfg.prop_gain});
			end
			MSEL_D: begin
				mul_a = vel_s1;
				mul_b = $signed({3'b000, cfg.damp_gain});
			end
			MSEL_G: begin
				mul_a = 32'(diff_s3);
				mul_b = $signed({1'b0, cfg.gear_factor});
			end
			default: begin
				mul_a = err_s1;
				mul_b = $signed({1'b0, cfg.prop_gain});
			end
		endcase
	end

	assign prod = 49'(mul_a) * 49'(mul_b);

	// p - d, limited to +/-2^28: beyond that any nonzero gear saturates the command
	assign diff_wide = 39'(p_s2) - 39'($signed(prod[45:10]));

	always_comb begin
		if (diff_wide > DIFF_HI) begin
			diff_sat = 30'(DIFF_HI);
		end else if (diff_wide < DIFF_LO) begin
			diff_sat = 30'(DIFF_LO);
		end else begin
			diff_sat = diff_wide[29:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_sel == MSEL_P) p_s2 <= prod[47:10];
		if (cmd.mul_sel == MSEL_D) diff_s3 <= diff_sat;
	end

	// Command clamp
	assign cmd_wide = prod[45:8];
	assign lim_pos  = $signed({18'd0, cfg.speed_limit});
	assign lim_neg  = -lim_pos;

	always_comb begin
		if (!en_s1) begin
			cmd_clamp = '0;
		end else if (cmd_wide > lim_pos) begin
			cmd_clamp = lim_pos[20:0];
		end else if (cmd_wide < lim_neg) begin
			cmd_clamp = lim_neg[20:0];
		end else begin
			cmd_clamp = cmd_wide[20:0];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load_result) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			res_cmd_q    <= cmd_clamp;
			res_err_q    <= en_s1 ? err_s1 : 32'sd0;
			res_tick_q   <= tick_q;
			res_active_q <= en_s1;
		end
	end

	assign stat.result_full  = res_valid_q;
	assign stat.result_taken = result_ready;

	assign result_valid   = res_valid_q;
	assign speed_command  = res_cmd_q;
	assign position_error = res_err_q;
	assign step_count     = res_tick_q;
	assign loop_active    = res_active_q;

endmodule

FILE: rtl/pd_position_loop_velocity_command.sv
// Flow: a sample request accepted on the input channel passes the error stage,
// then three passes of one 32x17 multiplier, and is shown on the result channel.
// The shared multiplier forms the proportional, damping and gear products in turn,
// so no new sample is taken until the last is through; a held result adds stall.
// Reset (arst_n low): registers back to defaults, setpoint, latched position,
// step count and enable history cleared, no result pending.
// ----------------------------------------------------------------------------
// PD position loop with velocity command
// Top level: register bank, sequencer and datapath on valid/ready channels.
// ----------------------------------------------------------------------------
module pd_position_loop_velocity_command import pdpl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	pdpl_in_if.sink               sample,
	pdpl_out_if.source            result
);

	cfg_t     cfg;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	pdpl_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	pdpl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pdpl_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.stat           (stat),
		.meas_position  (sample.meas_position),
		.meas_velocity  (sample.meas_velocity),
		.enable_level   (sample.enable_level),
		.new_target     (sample.new_target),
		.target_load    (sample.target_load),
		.result_valid   (result.valid),
		.result_ready   (result.ready),
		.speed_command  (result.speed_command),
		.position_error (result.position_error),
		.step_count     (result.step_count),
		.loop_active    (result.loop_active)
	);

endmodule

FILE: rtl/pdpl_checker.sv
// ----------------------------------------------------------------------------
// PD position loop port checker
// Watches the channels of the top level over time.
// ----------------------------------------------------------------------------
module pdpl_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               res_valid,
	input logic               res_ready,
	input logic signed [20:0] speed_command,
	input logic signed [31:0] position_error,
	input logic               loop_active
);

	// A pending result holds until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result request dropped before it was taken");

	// Sequencer refuses new samples while the multiplier passes of an accepted sample run
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
		else $error("sample accepted while multiplier still busy");

	// Disabled step reports zero command and zero error
	a_disabled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !loop_active |->
		speed_command == 21'sd0 && position_error == 32'sd0)
		else $error("nonzero output on a disabled step");

	// Command never exceeds the largest speed limit
	a_cmd_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |->
		speed_command <= 21'sd655360 && speed_command >= -21'sd655360)
		else $error("speed command out of range");

endmodule

bind pd_position_loop_velocity_command pdpl_checker u_pdpl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (sample.valid),
	.in_ready       (sample.ready),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.speed_command  (result.speed_command),
	.position_error (result.position_error),
	.loop_active    (result.loop_active)
);
